// ----- design/s5uhs_pkg.sv -----
`timescale 1ns / 1ps
// Package for the SOCKS5 UDP header strip: header positions, address type
// codes, record kinds and the item types shared by the pipeline stages.
// No dependencies.
package s5uhs_pkg;

  // Header byte positions; PosPayload marks the payload phase
  localparam logic [4:0] PosFrag    = 5'd2;
  localparam logic [4:0] PosAtyp    = 5'd3;
  localparam logic [4:0] PosPortV4  = 5'd8;
  localparam logic [4:0] PosPortV6  = 5'd20;
  localparam logic [4:0] PosPayload = 5'd31;

  // Field codes
  localparam logic [7:0] FragNone = 8'h00;
  localparam logic [7:0] AtypIpv4 = 8'h01;
  localparam logic [7:0] AtypIpv6 = 8'h04;

  localparam logic KindHeader  = 1'b0;
  localparam logic KindPayload = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_datagram;
  } in_item_t;

  typedef struct packed {
    logic        record_kind;
    logic        is_ipv6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] origin_port;
    logic [7:0]  payload_byte;
    logic        last;
  } res_item_t;

endpackage

// ----- design/s5uhs_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for datagram bytes in and records out.
// No dependencies.
interface s5uhs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_datagram;

  modport source (output valid, output data_byte, output end_of_datagram, input ready);
  modport sink (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

interface s5uhs_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic        is_ipv6;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [15:0] origin_port;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, output record_kind, output is_ipv6, output addr_high,
                  output addr_low, output origin_port, output payload_byte, output last,
                  input ready);
  modport sink (input valid, input record_kind, input is_ipv6, input addr_high,
                input addr_low, input origin_port, input payload_byte, input last,
                output ready);
endinterface

// ----- design/s5uhs_in_stage.sv -----
`timescale 1ns / 1ps
// Input register: captures one datagram byte request and hands it to the parser.
// Depends on s5uhs_pkg.
module s5uhs_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  s5uhs_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              item_valid,
  output s5uhs_pkg::in_item_t item
);
  import s5uhs_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  // Accept while empty or while the held request moves on
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Hold payload unless a new request comes in
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- design/s5uhs_parser.sv -----
`timescale 1ns / 1ps
// Header parser: tracks the position in the datagram, collects address and
// port, and forms one record per consumed byte where one is due. Depends on s5uhs_pkg.
module s5uhs_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  s5uhs_pkg::in_item_t  item,
  output logic                 res_valid,
  output s5uhs_pkg::res_item_t res
);
  import s5uhs_pkg::*;

  logic [4:0]  pos_r, pos_nxt;
  logic        wide_r, wide_nxt;
  logic        discard_r, discard_nxt;
  logic [63:0] addr_hi_r, addr_hi_nxt;
  logic [63:0] addr_lo_r, addr_lo_nxt;
  logic [7:0]  port_hi_r, port_hi_nxt;
  logic [4:0]  port_pos;
  logic [7:0]  b;

  assign b        = item.data_byte;
  assign port_pos = wide_r ? PosPortV6 : PosPortV4;

  // Next state and result for the byte at the head
  always_comb begin
    pos_nxt     = pos_r;
    wide_nxt    = wide_r;
    discard_nxt = discard_r;
    addr_hi_nxt = addr_hi_r;
    addr_lo_nxt = addr_lo_r;
    port_hi_nxt = port_hi_r;
    res_valid   = 1'b0;
    res         = '0;

    if (discard_r) begin
      // drop bytes up to the end of the datagram
    end else if (pos_r == PosPayload) begin
      res_valid        = 1'b1;
      res.record_kind  = KindPayload;
      res.payload_byte = b;
      res.last         = item.end_of_datagram;
    end else if (pos_r < PosFrag) begin
      pos_nxt = pos_r + 5'd1;
    end else if (pos_r == PosFrag) begin
      if (b != FragNone) begin
        discard_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + 5'd1;
      end
    end else if (pos_r == PosAtyp) begin
      addr_hi_nxt = '0;
      addr_lo_nxt = '0;
      if (b == AtypIpv4) begin
        wide_nxt = 1'b0;
        pos_nxt  = pos_r + 5'd1;
      end else if (b == AtypIpv6) begin
        wide_nxt = 1'b1;
        pos_nxt  = pos_r + 5'd1;
      end else begin
        discard_nxt = 1'b1;
      end
    end else if (pos_r < port_pos) begin
      addr_hi_nxt = {addr_hi_r[55:0], addr_lo_r[63:56]};
      addr_lo_nxt = {addr_lo_r[55:0], b};
      pos_nxt     = pos_r + 5'd1;
    end else if (pos_r == port_pos) begin
      port_hi_nxt = b;
      pos_nxt     = pos_r + 5'd1;
    end else begin
      res_valid       = 1'b1;
      res.record_kind = KindHeader;
      res.is_ipv6     = wide_r;
      res.addr_high   = wide_r ? addr_hi_r : 64'd0;
      res.addr_low    = wide_r ? addr_lo_r : {32'd0, addr_lo_r[31:0]};
      res.origin_port = {port_hi_r, b};
      res.last        = item.end_of_datagram;
      pos_nxt         = PosPayload;
    end

    // Return to start of datagram after the final byte
    if (item.end_of_datagram) begin
      pos_nxt     = '0;
      wide_nxt    = 1'b0;
      discard_nxt = 1'b0;
      addr_hi_nxt = '0;
      addr_lo_nxt = '0;
      port_hi_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      wide_r    <= 1'b0;
      discard_r <= 1'b0;
    end else if (step) begin
      pos_r     <= pos_nxt;
      wide_r    <= wide_nxt;
      discard_r <= discard_nxt;
    end
  end

  // Address and port bytes are always written before use
  always_ff @(posedge clk) begin
    if (step) begin
      addr_hi_r <= addr_hi_nxt;
      addr_lo_r <= addr_lo_nxt;
      port_hi_r <= port_hi_nxt;
    end
  end

endmodule

// ----- design/s5uhs_out_stage.sv -----
`timescale 1ns / 1ps
// Result register: holds one record until the receiver takes it.
// Depends on s5uhs_pkg.
module s5uhs_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  s5uhs_pkg::res_item_t res,
  output logic                 can_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output s5uhs_pkg::res_item_t out_item
);
  import s5uhs_pkg::*;

  logic      valid_r;
  res_item_t item_r;

  // Free when empty or when the held record leaves this cycle
  assign can_take  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_take) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res;
    end
  end

endmodule

// ----- design/socks5_udp_header_strip_top.sv -----
`timescale 1ns / 1ps
// SOCKS5 UDP header strip, top level. Depends on s5uhs_pkg, s5uhs_if and the
// s5uhs_in_stage, s5uhs_parser and s5uhs_out_stage modules.
//
// Usage:
//   in_ch carries one datagram byte per request, end_of_datagram set on the
//   final byte. out_ch carries records: a header record (record_kind 0) with
//   the source address and port once the port is complete, then one payload
//   record (record_kind 1) per payload byte. last marks the final record.
//   Datagrams with a nonzero fragment byte, an address type other than IPv4
//   or IPv6, or that end inside the header give no records at all.
//   Throughput: one byte per cycle while out_ch does not stall. A byte goes
//   through an input register, the parser logic and a result register: its
//   record is valid on out_ch once the result register has loaded it.
//   When out_ch stalls, the result register holds its record and the input
//   register holds one more byte; in_ch.ready then drops until the result
//   is taken.
//   Reset (rst_n low, synchronous) empties both registers and starts a new
//   datagram.
module socks5_udp_header_strip_top (
  input logic         clk,
  input logic         rst_n,
  s5uhs_in_if.sink    in_ch,
  s5uhs_out_if.source out_ch
);
  import s5uhs_pkg::*;

  in_item_t  in_item;
  in_item_t  item;
  logic      item_valid;
  logic      can_take;
  logic      advance;
  logic      res_valid;
  res_item_t res;
  res_item_t out_item;

  assign in_item.data_byte       = in_ch.data_byte;
  assign in_item.end_of_datagram = in_ch.end_of_datagram;

  // Advance the held byte when the result register has room
  assign advance = item_valid && can_take;

  s5uhs_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  s5uhs_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  s5uhs_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.record_kind  = out_item.record_kind;
  assign out_ch.is_ipv6      = out_item.is_ipv6;
  assign out_ch.addr_high    = out_item.addr_high;
  assign out_ch.addr_low     = out_item.addr_low;
  assign out_ch.origin_port  = out_item.origin_port;
  assign out_ch.payload_byte = out_item.payload_byte;
  assign out_ch.last         = out_item.last;

endmodule

// ----- verif/tb_socks5_udp_header_strip_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for socks5_udp_header_strip_top: feeds byte streams of
// good, rejected and truncated datagrams and checks every record against a
// built-in parser model. Depends on s5uhs_pkg, s5uhs_if and the design files.
module tb_socks5_udp_header_strip_top;
  import s5uhs_pkg::*;

  localparam int         RandomBytes = 650;
  localparam int         HoldCycles  = 80;
  localparam int         IdleLimit   = 1000;
  localparam int         DrainCycles = 8;
  localparam int         ModeCycles  = 150;
  localparam logic [7:0] AtypDomain  = 8'h03;

  typedef enum int {FormGood, FormBadFrag, FormBadAtyp, FormCut} dgram_form_t;
  typedef enum int {RdyAlways, RdyRandom, RdyPattern} ready_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Bench-side drivers of the channel inputs
  logic     drv_valid = 1'b0;
  in_item_t drv_item = '0;
  logic     rcv_ready = 1'b0;

  s5uhs_in_if  in_ch();
  s5uhs_out_if out_ch();

  assign in_ch.valid           = drv_valid;
  assign in_ch.data_byte       = drv_item.data_byte;
  assign in_ch.end_of_datagram = drv_item.end_of_datagram;
  assign out_ch.ready          = rcv_ready;

  socks5_udp_header_strip_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  in_item_t  byte_q[$];
  res_item_t record_q[$];

  // Parser model state
  logic [4:0]  hdr_pos = '0;
  bit          v6_addr = 1'b0;
  bit          dropping = 1'b0;
  logic [63:0] addr_hi = '0;
  logic [63:0] addr_lo = '0;
  logic [7:0]  port_hi = '0;

  int err_count = 0;
  int in_count = 0;
  int n_dgrams = 0;
  int n_hdr_v4 = 0;
  int n_hdr_v6 = 0;
  int n_payload = 0;
  int idle_cycles = 0;
  bit in_taken = 1'b0;

  int burst_left = 20;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int rcv_cycle = 0;
  ready_mode_t rdy_mode = RdyAlways;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_error(input string msg);
    if (err_count < 30) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Advance the parser model by one byte; return 1 when a record comes out
  function automatic bit strip_predict(input in_item_t it, output res_item_t rec);
    logic [4:0] pos;
    logic [4:0] port_pos;
    bit         got;
    pos = hdr_pos;
    got = 1'b0;
    rec = '0;
    if (dropping) begin
      got = 1'b0;
    end else if (pos == PosPayload) begin
      rec.record_kind  = KindPayload;
      rec.payload_byte = it.data_byte;
      rec.last         = it.end_of_datagram;
      got = 1'b1;
    end else if (pos < PosFrag) begin
      hdr_pos = pos + 5'd1;
    end else if (pos == PosFrag) begin
      if (it.data_byte != FragNone) dropping = 1'b1;
      else hdr_pos = pos + 5'd1;
    end else if (pos == PosAtyp) begin
      addr_hi = '0;
      addr_lo = '0;
      if (it.data_byte == AtypIpv4) begin
        v6_addr = 1'b0;
        hdr_pos = pos + 5'd1;
      end else if (it.data_byte == AtypIpv6) begin
        v6_addr = 1'b1;
        hdr_pos = pos + 5'd1;
      end else begin
        dropping = 1'b1;
      end
    end else begin
      port_pos = v6_addr ? PosPortV6 : PosPortV4;
      if (pos < port_pos) begin
        addr_hi = {addr_hi[55:0], addr_lo[63:56]};
        addr_lo = {addr_lo[55:0], it.data_byte};
        hdr_pos = pos + 5'd1;
      end else if (pos == port_pos) begin
        port_hi = it.data_byte;
        hdr_pos = pos + 5'd1;
      end else begin
        rec.record_kind = KindHeader;
        rec.is_ipv6     = v6_addr;
        rec.addr_high   = v6_addr ? addr_hi : 64'd0;
        rec.addr_low    = v6_addr ? addr_lo : {32'd0, addr_lo[31:0]};
        rec.origin_port = {port_hi, it.data_byte};
        rec.last        = it.end_of_datagram;
        got = 1'b1;
        hdr_pos = PosPayload;
      end
    end
    // Final byte: start over with a fresh datagram
    if (it.end_of_datagram) begin
      hdr_pos  = '0;
      v6_addr  = 1'b0;
      dropping = 1'b0;
      addr_hi  = '0;
      addr_lo  = '0;
      port_hi  = '0;
    end
    return got;
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.data_byte = b;
    it.end_of_datagram = last;
    byte_q = {byte_q, it};
  endtask

  // Build one datagram of the given form with random content; return its length
  task automatic queue_datagram(input dgram_form_t form, input int pay_len,
                                input int addr_fill, output int total);
    logic [7:0] hdr [0:21];
    int         hlen;
    int         i;
    logic [7:0] b;
    hdr[0] = 8'($urandom);
    hdr[1] = 8'($urandom);
    hdr[2] = FragNone;
    if ($urandom_range(0, 1) == 1) begin
      hdr[3] = AtypIpv6;
      hlen = 22;
    end else begin
      hdr[3] = AtypIpv4;
      hlen = 10;
    end
    for (i = 4; i < 22; i++) begin
      if (addr_fill == 1) hdr[i] = 8'h00;
      else if (addr_fill == 2) hdr[i] = 8'hFF;
      else hdr[i] = 8'($urandom);
    end
    total = hlen + pay_len;
    case (form)
      FormBadFrag: begin
        hdr[2] = 8'($urandom_range(1, 255));
        total = $urandom_range(3, total);
      end
      FormBadAtyp: begin
        if ($urandom_range(0, 1) == 1) begin
          hdr[3] = AtypDomain;
        end else begin
          do b = 8'($urandom); while (b == AtypIpv4 || b == AtypIpv6);
          hdr[3] = b;
        end
        total = $urandom_range(4, total);
      end
      FormCut: begin
        total = $urandom_range(1, hlen - 1);
      end
      default: begin
      end
    endcase
    for (i = 0; i < total; i++) begin
      b = (i < hlen) ? hdr[i] : 8'($urandom);
      queue_byte(b, i == total - 1);
    end
  endtask

  // Stimulus: directed datagrams, then random ones, then release reset and wait out the run
  initial begin
    int i;
    int pick;
    int pay_len;
    int fill;
    int len;
    int queued;
    dgram_form_t form;

    // IPv4 with all-ones reserved bytes, address and port, one zero payload byte
    for (i = 0; i < 2; i++) queue_byte(8'hFF, 1'b0);
    queue_byte(FragNone, 1'b0);
    queue_byte(AtypIpv4, 1'b0);
    for (i = 0; i < 6; i++) queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);
    // Nonzero fragment, ending on the fragment byte
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // Domain-name address type
    for (i = 0; i < 3; i++) queue_byte(8'h00, 1'b0);
    queue_byte(AtypDomain, 1'b0);
    queue_byte(8'h7E, 1'b1);
    // Datagram of a single byte
    queue_byte(8'hA5, 1'b1);
    // Header-only IPv4, all zero
    for (i = 0; i < 3; i++) queue_byte(8'h00, 1'b0);
    queue_byte(AtypIpv4, 1'b0);
    for (i = 0; i < 5; i++) queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);

    // Random datagrams, mostly well formed
    queued = 0;
    while (queued < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) form = FormGood;
      else if (pick < 78) form = FormBadFrag;
      else if (pick < 86) form = FormBadAtyp;
      else form = FormCut;
      pay_len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 40);
      pick = $urandom_range(0, 9);
      fill = (pick == 0) ? 1 : ((pick == 1) ? 2 : 0);
      queue_datagram(form, pay_len, fill, len);
      queued += len;
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || drv_valid) @(negedge clk);
    while (record_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("Covered %0d datagrams, %0d bytes: %0d IPv4 and %0d IPv6 headers, %0d dropped,",
             n_dgrams, in_count, n_hdr_v4, n_hdr_v6, n_dgrams - n_hdr_v4 - n_hdr_v6);
    $display("%0d payload records checked, %0d mismatches.", n_payload, err_count);
    if (err_count == 0) begin
      $display("socks5_udp_header_strip_top test passed");
    end else begin
      $display("socks5_udp_header_strip_top test failed");
    end
    $finish;
  end

  // Sender: drive requests in bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        drv_valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        drv_item <= byte_q.pop_front();
        drv_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 10);
          gap_left = $urandom_range(1, 4);
        end
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Receiver: rotate through stall modes, with one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      rcv_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rcv_ready <= 1'b0;
    end else if (!hold_done && in_count >= 200) begin
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      rcv_ready <= 1'b0;
    end else begin
      rcv_cycle++;
      if (rcv_cycle % ModeCycles == 0) begin
        case (rdy_mode)
          RdyAlways: rdy_mode = RdyRandom;
          RdyRandom: rdy_mode = RdyPattern;
          default:   rdy_mode = RdyAlways;
        endcase
      end
      case (rdy_mode)
        RdyAlways: rcv_ready <= 1'b1;
        RdyRandom: rcv_ready <= ($urandom_range(0, 2) != 0);
        default:   rcv_ready <= (rcv_cycle % 7 >= 3);
      endcase
    end
  end

  // Monitor: predict on accepted bytes, check accepted records
  always @(posedge clk) begin : monitor
    res_item_t rec;
    res_item_t want;
    in_item_t  it;
    bit        got;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        in_count++;
        it.data_byte = in_ch.data_byte;
        it.end_of_datagram = in_ch.end_of_datagram;
        if (it.end_of_datagram) n_dgrams++;
        got = strip_predict(it, rec);
        if (got) record_q = {record_q, rec};
      end
      if (out_ch.valid && out_ch.ready) begin
        if (record_q.size() == 0) begin
          report_error($sformatf("unexpected record, kind %0d", out_ch.record_kind));
        end else begin
          want = record_q.pop_front();
          if (want.record_kind == KindPayload) n_payload++;
          else if (want.is_ipv6) n_hdr_v6++;
          else n_hdr_v4++;
          check_field("record_kind", out_ch.record_kind, want.record_kind);
          check_field("is_ipv6", out_ch.is_ipv6, want.is_ipv6);
          check_field("addr_high", out_ch.addr_high, want.addr_high);
          check_field("addr_low", out_ch.addr_low, want.addr_low);
          check_field("origin_port", out_ch.origin_port, want.origin_port);
          check_field("payload_byte", out_ch.payload_byte, want.payload_byte);
          check_field("last", out_ch.last, want.last);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready))
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout: %0d records still expected", record_q.size());
      $display("socks5_udp_header_strip_top test failed");
      $finish;
    end
  end

endmodule
